>>> design/ps2s1_pkg.sv
// ----------------------------------------------------------------------------
// ps2s1_pkg
// Shared constants, types and keycode tables of the PS/2 set 1 decoder.
// ----------------------------------------------------------------------------
package ps2s1_pkg;

  localparam logic [7:0] PREFIX_EXT   = 8'hE0;
  localparam logic [7:0] PREFIX_PAUSE = 8'hE1;

  localparam logic [6:0] KC_LSHIFT = 7'd42;
  localparam logic [6:0] KC_RSHIFT = 7'd54;
  localparam logic [6:0] KC_LCTRL  = 7'd29;
  localparam logic [6:0] KC_RCTRL  = 7'd97;
  localparam logic [6:0] KC_ALT    = 7'd56;
  localparam logic [6:0] KC_ALTGR  = 7'd100;
  localparam logic [6:0] KC_CAPS   = 7'd58;
  localparam logic [6:0] KC_NONE   = 7'd0;

  typedef struct packed {
    logic [6:0] key_code;
    logic       shift_active;
    logic       ctrl_active;
    logic       alt_active;
    logic       altgr_active;
  } key_result_t;

  // Plain table: most codes map to themselves.
  function automatic logic [6:0] plain_code(input logic [6:0] idx);
    logic [6:0] code;
    code = KC_NONE;
    if (idx >= 7'd1 && idx <= 7'd83) begin
      code = idx;
    end else begin
      case (idx)
        7'd84:   code = 7'd99;
        7'd86:   code = 7'd86;
        7'd87:   code = 7'd87;
        7'd88:   code = 7'd88;
        default: code = KC_NONE;
      endcase
    end
    return code;
  endfunction

  // Table used after the E0 prefix.
  function automatic logic [6:0] ext_code(input logic [6:0] idx);
    logic [6:0] code;
    code = KC_NONE;
    case (idx)
      7'd28:   code = 7'd28;
      7'd29:   code = KC_RCTRL;
      7'd53:   code = 7'd55;
      7'd56:   code = KC_ALTGR;
      7'd71:   code = 7'd71;
      7'd72:   code = 7'd72;
      7'd73:   code = 7'd73;
      7'd75:   code = 7'd75;
      7'd77:   code = 7'd77;
      7'd79:   code = 7'd79;
      7'd80:   code = 7'd80;
      7'd81:   code = 7'd81;
      7'd82:   code = 7'd82;
      7'd83:   code = 7'd83;
      default: code = KC_NONE;
    endcase
    return code;
  endfunction

  function automatic logic is_letter(input logic [6:0] k);
    return (k >= 7'd16 && k <= 7'd25) || (k >= 7'd30 && k <= 7'd38) ||
           (k >= 7'd44 && k <= 7'd50);
  endfunction

  function automatic logic is_modifier(input logic [6:0] k);
    return (k == KC_LSHIFT) || (k == KC_RSHIFT) || (k == KC_LCTRL) ||
           (k == KC_RCTRL) || (k == KC_ALT) || (k == KC_ALTGR) || (k == KC_CAPS);
  endfunction

endpackage

>>> design/ps2s1_decode.sv
// ----------------------------------------------------------------------------
// ps2s1_decode
// Translates one registered scancode byte and keeps the prefix and modifier
// flags; the flags advance only when the byte is consumed.
// ----------------------------------------------------------------------------
module ps2s1_decode
  import ps2s1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  byte_in,
  output logic        emit,
  output key_result_t result
);

  logic extended_pending, shift_held, ctrl_held, alt_held, altgr_held, caps_locked;
  logic extended_pending_next, shift_held_next, ctrl_held_next;
  logic alt_held_next, altgr_held_next, caps_locked_next;

  logic       is_prefix;
  logic       release_bit;
  logic [6:0] key;
  logic       key_valid;
  logic       caps_toggle;

  assign is_prefix   = (byte_in == PREFIX_EXT) || (byte_in == PREFIX_PAUSE);
  assign release_bit = byte_in[7];
  assign key         = extended_pending ? ext_code(byte_in[6:0]) : plain_code(byte_in[6:0]);
  assign key_valid   = !is_prefix && (key != KC_NONE);
  assign caps_toggle = advance && key_valid && (key == KC_CAPS) && !release_bit;

  assign emit = advance && key_valid && !is_modifier(key) && !release_bit;

  always_comb begin
    result.key_code     = key;
    result.shift_active = shift_held ^ (caps_locked && is_letter(key));
    result.ctrl_active  = ctrl_held;
    result.alt_active   = alt_held;
    result.altgr_active = altgr_held;
  end

  always_comb begin
    extended_pending_next = extended_pending;
    shift_held_next       = shift_held;
    ctrl_held_next        = ctrl_held;
    alt_held_next         = alt_held;
    altgr_held_next       = altgr_held;
    caps_locked_next      = caps_locked;
    if (advance) begin
      extended_pending_next = (byte_in == PREFIX_EXT);
      if (key_valid) begin
        case (key)
          KC_LSHIFT, KC_RSHIFT: shift_held_next = !release_bit;
          KC_LCTRL, KC_RCTRL:   ctrl_held_next  = !release_bit;
          KC_ALT:               alt_held_next   = !release_bit;
          KC_ALTGR:             altgr_held_next = !release_bit;
          KC_CAPS:              caps_locked_next = caps_locked ^ !release_bit;
          default:              ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
      shift_held       <= 1'b0;
      ctrl_held        <= 1'b0;
      alt_held         <= 1'b0;
      altgr_held       <= 1'b0;
      caps_locked      <= 1'b0;
    end else begin
      extended_pending <= extended_pending_next;
      shift_held       <= shift_held_next;
      ctrl_held        <= ctrl_held_next;
      alt_held         <= alt_held_next;
      altgr_held       <= altgr_held_next;
      caps_locked      <= caps_locked_next;
    end
  end

  // An emitted key is never one of the modifiers.
  a_emit_not_modifier: assert property (@(posedge clk) disable iff (rst)
    emit |-> (key != KC_LSHIFT && key != KC_RSHIFT && key != KC_LCTRL &&
              key != KC_RCTRL && key != KC_ALT && key != KC_ALTGR && key != KC_CAPS))
    else $error("modifier key emitted as a result");

  // A consumed E0 byte arms the extended table for the next byte.
  a_prefix_arms: assert property (@(posedge clk) disable iff (rst)
    (advance && byte_in == PREFIX_EXT) |=> extended_pending)
    else $error("extended prefix not armed");

  // Caps lock changes only after a consumed caps lock press.
  a_caps_only_on_press: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && caps_locked != $past(caps_locked)) |-> $past(caps_toggle))
    else $error("caps lock changed without a caps lock press");

endmodule

>>> design/ps2s1_out_reg.sv
// ----------------------------------------------------------------------------
// ps2s1_out_reg
// Result register that holds one decoded key until the consumer takes it.
// ----------------------------------------------------------------------------
module ps2s1_out_reg
  import ps2s1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  key_result_t load_data,
  input  logic        out_ready,
  output logic        out_valid,
  output key_result_t data
);

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

>>> design/ps2s1_scancode_decoder_unit.sv
// ----------------------------------------------------------------------------
// ps2_set1_scancode_decoder_unit
// Decodes PS/2 scancode set 1 bytes into key presses with modifier state.
// ----------------------------------------------------------------------------
// Each request carries one raw set 1 byte from the keyboard. The byte is
// captured in an input register, translated combinationally through the plain
// or extended keycode table, and a press of a non-modifier key is placed in
// the result register together with the current shift, ctrl, alt and altgr
// flags. Shift is inverted by caps lock for letter keys. Prefix bytes (E0,
// E1), releases, unmapped codes and modifier keys produce no result but do
// update the internal flags. The block takes one request per cycle when not
// stalled: a byte waits in the input register and is written into the result
// register once that register is empty or being read, where it stays valid
// until the consumer takes it.
// Backpressure from the result side stalls the input register only while
// the result register is full and not being drained.
// ----------------------------------------------------------------------------
module ps2_set1_scancode_decoder_unit
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] key_code,
  output logic       shift_active,
  output logic       ctrl_active,
  output logic       alt_active,
  output logic       altgr_active
);

  // Input register: holds one byte waiting to be decoded.
  logic        byte_valid;
  logic [7:0]  byte_reg;
  logic        byte_valid_next;
  logic        advance;
  logic        emit;
  key_result_t dec_result;
  key_result_t out_data;

  // The decoded byte moves on whenever the result register can take a new
  // value, i.e. it is empty or being read in this cycle.
  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  always_comb begin
    byte_valid_next = byte_valid;
    if (in_valid && in_ready) begin
      byte_valid_next = 1'b1;
    end else if (advance) begin
      byte_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      byte_valid <= byte_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= scan_byte;
    end
  end

  // Table lookup and modifier tracking.
  ps2s1_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (byte_reg),
    .emit    (emit),
    .result  (dec_result)
  );

  // Result register.
  ps2s1_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_data (dec_result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .data      (out_data)
  );

  assign key_code     = out_data.key_code;
  assign shift_active = out_data.shift_active;
  assign ctrl_active  = out_data.ctrl_active;
  assign alt_active   = out_data.alt_active;
  assign altgr_active = out_data.altgr_active;

  // A delivered key code is never the unmapped code.
  a_key_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_code != KC_NONE))
    else $error("result carries an unmapped key code");

endmodule
